[hw/rtl/xbm_pkg.sv]
// shared types and constants for the bitmap blitter
package xbm_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BITMAP_WIDTH  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BITMAP_HEIGHT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROTATION_MODE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSPARENT   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_COLOUR   = 3'd6;

  localparam int unsigned CFG_DATA_BITS = 8;
  localparam int unsigned PIXELS_PER_BYTE = 8;
  localparam int unsigned BIT_INDEX_BITS = 3;

  // rotation mode bits
  localparam int unsigned ROT_BIT = 0;
  localparam int unsigned MIR_BIT = 1;

  // job queue between decoder and pixel emitter
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;
  localparam int unsigned QUEUE_COUNT_BITS = 3;

  // one decoded byte, coordinates travel beside it
  typedef struct packed {
    logic                       rot;
    logic                       done;
    logic [PIXELS_PER_BYTE-1:0] emit_mask;
    logic [PIXELS_PER_BYTE-1:0] colour_bits;
  } job_t;

endpackage

[hw/rtl/xbm_front.sv]
// decoder: configuration registers, row counters and per-byte job build
module xbm_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [xbm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [xbm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                accept,
  input  logic [7:0]                          bitmap_byte,
  output logic                                job_push,
  output xbm_pkg::job_t                       job,
  output logic [COORD_BITS-1:0]               job_fixed,
  output logic [COORD_BITS-1:0]               job_move
);

  logic [7:0] origin_x;
  logic [7:0] origin_y;
  logic [7:0] bitmap_width;
  logic [7:0] bitmap_height;
  logic [1:0] rotation_mode;
  logic       transparent_zeros;
  logic       draw_colour;

  logic [7:0] row_index;
  logic [4:0] byte_in_row;

  logic                  rot;
  logic                  mir;
  logic [5:0]            row_bytes;
  logic                  row_end;
  logic                  done;
  logic                  byte_in_range;
  logic [7:0]            i_base;
  logic [7:0]            emit_mask;
  logic [COORD_BITS-1:0] bx;
  logic [COORD_BITS-1:0] by;
  logic [COORD_BITS-1:0] row_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x          <= 8'd0;
      origin_y          <= 8'd0;
      bitmap_width      <= 8'd1;
      bitmap_height     <= 8'd1;
      rotation_mode     <= 2'd0;
      transparent_zeros <= 1'b0;
      draw_colour       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        xbm_pkg::REG_ORIGIN_X:      origin_x          <= cfg_data;
        xbm_pkg::REG_ORIGIN_Y:      origin_y          <= cfg_data;
        xbm_pkg::REG_BITMAP_WIDTH:  bitmap_width      <= cfg_data;
        xbm_pkg::REG_BITMAP_HEIGHT: bitmap_height     <= cfg_data;
        xbm_pkg::REG_ROTATION_MODE: rotation_mode     <= cfg_data[1:0];
        xbm_pkg::REG_TRANSPARENT:   transparent_zeros <= cfg_data[0];
        xbm_pkg::REG_DRAW_COLOUR:   draw_colour       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rot       = rotation_mode[xbm_pkg::ROT_BIT];
    mir       = rotation_mode[xbm_pkg::MIR_BIT];
    row_bytes = 6'((9'(bitmap_width) + 9'd7) >> 3);
    row_end   = (6'(byte_in_row) + 6'd1) >= row_bytes;
    done      = row_end && ((9'(row_index) + 9'd1) >= 9'(bitmap_height));
    byte_in_range = 6'(byte_in_row) < row_bytes;
    i_base    = {byte_in_row, 3'b000};

    bx = COORD_BITS'(origin_x);
    by = COORD_BITS'(origin_y);
    if (rot && !mir) begin
      bx = bx + COORD_BITS'(bitmap_width) + COORD_BITS'(1);
    end else if (mir && !rot) begin
      by = by + COORD_BITS'(bitmap_height) - COORD_BITS'(1);
    end

    row_term = COORD_BITS'(row_index);
    if (mir) begin
      if (rot) bx = bx + row_term;
      else     by = by - row_term;
    end else begin
      if (rot) bx = bx - row_term;
      else     by = by + row_term;
    end

    for (int b = 0; b < xbm_pkg::PIXELS_PER_BYTE; b++) begin
      emit_mask[b] = byte_in_range
                     && ({byte_in_row, xbm_pkg::BIT_INDEX_BITS'(b)} < bitmap_width)
                     && (bitmap_byte[b] || !transparent_zeros);
    end

    job.rot         = rot;
    job.done        = done;
    job.emit_mask   = emit_mask;
    // a set bit takes the draw colour, a clear bit its inverse
    job.colour_bits = bitmap_byte ^ {8{~draw_colour}};

    job_fixed = rot ? bx : by;
    job_move  = (rot ? by : bx) + COORD_BITS'(i_base);
    job_push  = accept && (emit_mask != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= 8'd0;
      byte_in_row <= 5'd0;
    end else if (accept) begin
      if (done) begin
        row_index   <= 8'd0;
        byte_in_row <= 5'd0;
      end else if (row_end) begin
        row_index   <= row_index + 8'd1;
        byte_in_row <= 5'd0;
      end else begin
        byte_in_row <= byte_in_row + 5'd1;
      end
    end
  end

endmodule

[hw/rtl/xbm_job_queue.sv]
// small first-in first-out queue of decoded byte jobs
module xbm_job_queue #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_in,
  input  logic [WIDTH-1:0] data_in,
  output logic             full_out,
  input  logic             pop_in,
  output logic             valid_out,
  output logic [WIDTH-1:0] data_out
);

  logic [WIDTH-1:0]                       slots [xbm_pkg::QUEUE_DEPTH];
  logic [xbm_pkg::QUEUE_PTR_BITS-1:0]     head;
  logic [xbm_pkg::QUEUE_PTR_BITS-1:0]     tail;
  logic [xbm_pkg::QUEUE_COUNT_BITS-1:0]   count;
  logic                                   do_push;
  logic                                   do_pop;

  assign full_out  = count == xbm_pkg::QUEUE_COUNT_BITS'(xbm_pkg::QUEUE_DEPTH);
  assign valid_out = count != '0;
  assign data_out  = slots[head];
  assign do_push   = push_in && !full_out;
  assign do_pop    = pop_in && valid_out;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= tail + 1'b1;
      if (do_pop)  head <= head + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= xbm_pkg::QUEUE_COUNT_BITS'(xbm_pkg::QUEUE_DEPTH))
    else $error("job queue count past depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push_in && full_out))
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop_in && !valid_out))
    else $error("job popped from empty queue");
`endif

endmodule

[hw/rtl/xbm_back.sv]
// pixel emitter: walks the emit mask of a job, one pixel write per cycle while the output is taken
module xbm_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  xbm_pkg::job_t         q_job,
  input  logic [COORD_BITS-1:0] q_fixed,
  input  logic [COORD_BITS-1:0] q_move,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_take,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  pixel_colour,
  output logic                  last_of_byte,
  output logic                  bitmap_done
);

  logic                  cur_valid;
  xbm_pkg::job_t         cur_job;
  logic [COORD_BITS-1:0] cur_fixed;
  logic [COORD_BITS-1:0] cur_move;

  logic                                 advance;
  logic                                 last;
  logic [xbm_pkg::BIT_INDEX_BITS-1:0]   bit_sel;
  logic [xbm_pkg::PIXELS_PER_BYTE-1:0]  mask_rest;
  logic [COORD_BITS-1:0]                along;

  always_comb begin
    bit_sel = '0;
    for (int b = xbm_pkg::PIXELS_PER_BYTE - 1; b >= 0; b--) begin
      if (cur_job.emit_mask[b]) bit_sel = xbm_pkg::BIT_INDEX_BITS'(b);
    end
    // drop the lowest set bit
    mask_rest = cur_job.emit_mask & (cur_job.emit_mask - 1'b1);
    last      = mask_rest == '0;
    along     = cur_move + COORD_BITS'(bit_sel);
    advance   = cur_valid && (!out_valid || out_take);
    q_pop     = q_valid && (!cur_valid || (advance && last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
    end else if (advance && last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_job   <= q_job;
      cur_fixed <= q_fixed;
      cur_move  <= q_move;
    end else if (advance) begin
      cur_job.emit_mask <= mask_rest;
    end
  end

  // output register, holds the request until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_x      <= cur_job.rot ? cur_fixed : along;
      pixel_y      <= cur_job.rot ? along : cur_fixed;
      pixel_colour <= cur_job.colour_bits[bit_sel];
      last_of_byte <= last;
      bitmap_done  <= cur_job.done;
    end
  end

`ifndef ASSERT_OFF
  a_job_has_pixels: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_job.emit_mask != '0))
    else $error("active job with empty emit mask");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (q_pop && cur_valid) |-> (advance && last))
    else $error("job loaded over unfinished job");
`endif

endmodule

[hw/rtl/xbm_bitmap_blit_rotate_core.sv]
// Bitmap blitter top level. Bytes of a 1-bit bitmap go in row order through
// push/full, one byte per cycle while full is low; a decoder turns each byte
// into a job (base coordinates, colour per bit, mask of pixels to write) and
// steps the row counters, and a four-entry job queue feeds the pixel emitter,
// which gives one pixel write per cycle while pop keeps up, through an output
// register read with empty/pop. A byte that writes n pixels (at most eight)
// holds the emitter for all n writes, so the single pixel write port sets the
// sustained byte rate; bytes that write nothing never reach the queue. A
// byte's first write passes the job queue, the emitter's job register and
// the output register. The user writes configuration only while the block
// is idle, through cfg_we/cfg_index/cfg_data; the block does not enforce it.
module xbm_bitmap_blit_rotate_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [xbm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [xbm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          bitmap_byte,
  output logic                                empty,
  input  logic                                pop,
  output logic [COORD_BITS-1:0]               pixel_x,
  output logic [COORD_BITS-1:0]               pixel_y,
  output logic                                pixel_colour,
  output logic                                last_of_byte,
  output logic                                bitmap_done
);

  localparam int unsigned QUEUE_WIDTH = $bits(xbm_pkg::job_t) + 2 * COORD_BITS;

  logic                   accept;
  logic                   job_push;
  xbm_pkg::job_t          job;
  logic [COORD_BITS-1:0]  job_fixed;
  logic [COORD_BITS-1:0]  job_move;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [QUEUE_WIDTH-1:0] q_data;
  xbm_pkg::job_t          q_job;
  logic [COORD_BITS-1:0]  q_fixed;
  logic [COORD_BITS-1:0]  q_move;
  logic                   out_valid;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;
  assign {q_job, q_fixed, q_move} = q_data;

  xbm_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .bitmap_byte(bitmap_byte),
    .job_push   (job_push),
    .job        (job),
    .job_fixed  (job_fixed),
    .job_move   (job_move)
  );

  xbm_job_queue #(
    .WIDTH(QUEUE_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_in  (job_push),
    .data_in  ({job, job_fixed, job_move}),
    .full_out (q_full),
    .pop_in   (q_pop),
    .valid_out(q_valid),
    .data_out (q_data)
  );

  xbm_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_fixed     (q_fixed),
    .q_move      (q_move),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_take    (pop),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_colour(pixel_colour),
    .last_of_byte(last_of_byte),
    .bitmap_done (bitmap_done)
  );

endmodule

[test/xbm_pixel_check.sv]
// pixel write predictor and comparator for the bitmap blitter
`timescale 1ns / 1ps

module xbm_pixel_check
  import xbm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      push,
  input  logic                      full,
  input  logic [7:0]                bitmap_byte,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [15:0]               pixel_x,
  input  logic [15:0]               pixel_y,
  input  logic                      pixel_colour,
  input  logic                      last_of_byte,
  input  logic                      bitmap_done,
  output int                        mismatches,
  output int                        writes_owed
);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        colour;
    logic        last;
    logic        done;
  } pixel_write_t;

  pixel_write_t pending_writes[$];

  // shadow of the register file and of the row counters
  logic [7:0] org_x, org_y, bm_w, bm_h;
  logic [1:0] rot_mode;
  logic       skip_zeros, ink;
  logic [7:0] row_idx;
  logic [4:0] byte_idx;

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (mismatches < 100) $error("%s expected %0d got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // turn one bitmap byte into the pixel writes it owes, then step the counters
  task automatic predict_byte(input logic [7:0] data);
    pixel_write_t wr [8];
    pixel_write_t pw;
    logic         rot, mir, row_end, done;
    logic [15:0]  bx, by;
    int           row_bytes, idx, n;
    rot = rot_mode[ROT_BIT];
    mir = rot_mode[MIR_BIT];
    row_bytes = (int'(bm_w) + 7) / 8;
    row_end = int'(byte_idx) + 1 >= row_bytes;
    done = row_end && (int'(row_idx) + 1 >= int'(bm_h));
    bx = 16'(org_x);
    by = 16'(org_y);
    if (rot && !mir) bx = bx + 16'(bm_w) + 16'd1;
    else if (mir && !rot) by = by + 16'(bm_h) - 16'd1;
    if (mir) begin
      if (rot) bx = bx + 16'(row_idx);
      else by = by - 16'(row_idx);
    end else begin
      if (rot) bx = bx - 16'(row_idx);
      else by = by + 16'(row_idx);
    end
    n = 0;
    for (int b = 0; b < 8; b++) begin
      idx = int'(byte_idx) * 8 + b;
      // past the row length or into the padding bits
      if (int'(byte_idx) >= row_bytes || idx >= int'(bm_w)) break;
      if (!data[b] && skip_zeros) continue;
      pw.x = rot ? bx : bx + 16'(idx);
      pw.y = rot ? by + 16'(idx) : by;
      pw.colour = data[b] ? ink : ~ink;
      pw.last = 1'b0;
      pw.done = done;
      wr[n] = pw;
      n++;
    end
    for (int k = 0; k < n; k++) begin
      pw = wr[k];
      pw.last = (k == n - 1);
      pending_writes.push_back(pw);
    end
    if (done) begin
      row_idx = '0;
      byte_idx = '0;
    end else if (row_end) begin
      row_idx = row_idx + 8'd1;
      byte_idx = '0;
    end else begin
      byte_idx = byte_idx + 5'd1;
    end
  endtask

  always @(posedge clk) begin
    pixel_write_t want;
    if (rst) begin
      org_x = '0;
      org_y = '0;
      bm_w = 8'd1;
      bm_h = 8'd1;
      rot_mode = '0;
      skip_zeros = 1'b0;
      ink = 1'b1;
      row_idx = '0;
      byte_idx = '0;
      pending_writes.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:      org_x = cfg_data;
          REG_ORIGIN_Y:      org_y = cfg_data;
          REG_BITMAP_WIDTH:  bm_w = cfg_data;
          REG_BITMAP_HEIGHT: bm_h = cfg_data;
          REG_ROTATION_MODE: rot_mode = cfg_data[1:0];
          REG_TRANSPARENT:   skip_zeros = cfg_data[0];
          REG_DRAW_COLOUR:   ink = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) predict_byte(bitmap_byte);
      if (pop && !empty) begin
        if (pending_writes.size() == 0) begin
          if (mismatches < 100)
            $error("pixel write with nothing owed at x=%0d y=%0d", pixel_x, pixel_y);
          mismatches++;
        end else begin
          want = pending_writes.pop_front();
          check_field("pixel_x", want.x, pixel_x);
          check_field("pixel_y", want.y, pixel_y);
          check_field("pixel_colour", 16'(want.colour), 16'(pixel_colour));
          check_field("last_of_byte", 16'(want.last), 16'(last_of_byte));
          check_field("bitmap_done", 16'(want.done), 16'(bitmap_done));
        end
      end
    end
    writes_owed = pending_writes.size();
  end

endmodule

[test/tb_top.sv]
// stimulus, watchdog and verdict for the bitmap blitter
`timescale 1ns / 1ps

module tb_top;
  import xbm_pkg::*;

  localparam int RANDOM_BYTES = 330;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 10;

  localparam logic [1:0] MODE_PLAIN   = 2'd0;
  localparam logic [1:0] MODE_ROTATE  = 2'd1;
  localparam logic [1:0] MODE_MIRROR  = 2'd2;
  localparam logic [1:0] MODE_ROT_MIR = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      push = 1'b0;
  logic                      full;
  logic [7:0]                bitmap_byte = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic [15:0]               pixel_x, pixel_y;
  logic                      pixel_colour, last_of_byte, bitmap_done;
  int                        mismatches, writes_owed;
  int                        stall_cycles = 0;
  bit                        quiet_send = 1'b0;

  always #2 clk = ~clk;

  xbm_bitmap_blit_rotate_core dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .push, .full, .bitmap_byte,
    .empty, .pop, .pixel_x, .pixel_y, .pixel_colour, .last_of_byte, .bitmap_done
  );

  xbm_pixel_check pixel_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .push, .full, .bitmap_byte,
    .empty, .pop, .pixel_x, .pixel_y, .pixel_colour, .last_of_byte, .bitmap_done,
    .mismatches, .writes_owed
  );

  // leaves cfg_we high, the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] ox, input logic [7:0] oy,
                           input logic [7:0] w, input logic [7:0] h,
                           input logic [1:0] mode, input logic tz, input logic col);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_BITMAP_WIDTH, w);
    write_reg(REG_BITMAP_HEIGHT, h);
    write_reg(REG_ROTATION_MODE, 8'(mode));
    write_reg(REG_TRANSPARENT, 8'(tz));
    write_reg(REG_DRAW_COLOUR, 8'(col));
    cfg_we <= 1'b0;
  endtask

  // push stays high between back-to-back requests
  task automatic send_byte(input logic [7:0] b);
    while (!quiet_send && $urandom_range(99) < 18) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    bitmap_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // lower push, wait for every owed write, then let silent bytes finish
  task automatic drain;
    push <= 1'b0;
    do @(negedge clk); while (writes_owed != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_origin();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // receiver: random pops, a quiet stretch and two long hold-offs
  initial begin
    int served, hold_left, holds;
    served = 0;
    hold_left = 0;
    holds = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty) served++;
      if (hold_left == 0 && ((holds == 0 && served >= 500) ||
                             (holds == 1 && served >= 1200))) begin
        hold_left = 300;
        holds++;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (served >= 100 && served < 400) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 18);
      end
    end
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int         sent, nbytes;
    logic [7:0] w, h;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // register defaults: one pixel per bitmap
    send_byte(8'h01);
    send_byte(8'h00);
    drain();

    // far corner, inverse colour, padding in the last byte of each row
    configure(8'd255, 8'd255, 8'd10, 8'd2, MODE_PLAIN, 1'b0, 1'b0);
    send_byte(8'hFF);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'hAA);
    drain();

    // rotate with transparency; final byte writes nothing
    configure(8'd0, 8'd255, 8'd9, 8'd2, MODE_ROTATE, 1'b1, 1'b1);
    send_byte(8'h00);
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(8'h00);
    drain();

    // mirror, then the height shrinks under the bitmap
    configure(8'd200, 8'd10, 8'd8, 8'd3, MODE_MIRROR, 1'b0, 1'b1);
    send_byte(8'h80);
    send_byte(8'h7F);
    drain();
    write_reg(REG_BITMAP_HEIGHT, 8'd1);
    cfg_we <= 1'b0;
    send_byte(8'hC3);
    drain();

    // rotate and mirror, then the width shrinks in the middle of a row
    configure(8'd17, 8'd3, 8'd16, 8'd2, MODE_ROT_MIR, 1'b0, 1'b0);
    send_byte(8'h12);
    drain();
    write_reg(REG_BITMAP_WIDTH, 8'd8);
    cfg_we <= 1'b0;
    send_byte(8'h34);
    send_byte(8'h56);
    drain();

    // zero width, then zero height
    configure(8'd5, 8'd5, 8'd0, 8'd3, MODE_PLAIN, 1'b0, 1'b1);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    drain();
    configure(8'd250, 8'd250, 8'd4, 8'd0, MODE_ROTATE, 1'b1, 1'b1);
    send_byte(8'hFF);
    send_byte(8'h0F);
    drain();

    // random bitmaps, mostly whole, some cut short
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      case ($urandom_range(19))
        0: w = 8'd0;
        1: w = 8'd255;
        2: w = 8'd8;
        default: w = 8'($urandom_range(24, 1));
      endcase
      case ($urandom_range(19))
        0: h = 8'd0;
        1: h = 8'd255;
        default: h = 8'($urandom_range(4, 1));
      endcase
      configure(pick_origin(), pick_origin(), w, h, 2'($urandom_range(3)),
                1'($urandom_range(1)), 1'($urandom_range(1)));
      if (w == 0 || h == 0) nbytes = $urandom_range(6, 1);
      else nbytes = ((int'(w) + 7) / 8) * int'(h);
      if ($urandom_range(4) == 0 || nbytes > 40)
        nbytes = $urandom_range(nbytes > 40 ? 40 : nbytes, 1);
      for (int k = 0; k < nbytes; k++) begin
        quiet_send = (sent >= 120 && sent < 200);
        send_byte(pick_byte());
        sent++;
      end
      drain();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && writes_owed == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

[xbm_bitmap_blit_rotate_core.f]
hw/rtl/xbm_pkg.sv
hw/rtl/xbm_front.sv
hw/rtl/xbm_job_queue.sv
hw/rtl/xbm_back.sv
hw/rtl/xbm_bitmap_blit_rotate_core.sv
test/xbm_pixel_check.sv
test/tb_top.sv
